@@ hw/rtl/mbcts_pkg.sv @@
package mbcts_pkg;

  // Default sizing
  localparam int DEF_MAX_ENTRIES     = 128;
  localparam int DEF_MAX_ENTRY_BYTES = 8;

  // Byte masks for seven-bit and full eight-bit compare
  localparam logic [7:0] LOW7_MASK = 8'h7F;
  localparam logic [7:0] FULL_MASK = 8'hFF;

  // Request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] REG_DEFAULT_DUP = 2'd1;
  localparam logic [1:0] REG_SEVEN_BIT   = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [6:0]  entry_index;
    logic [63:0] entry_text;
    logic [3:0]  entry_dup;
    logic [6:0]  entry_code;
    logic [63:0] query_bytes;
    logic        canonical;
  } in_item_t;

  typedef struct packed {
    logic       matched;
    logic [3:0] match_length;
    logic [6:0] char_code;
  } out_item_t;

  typedef struct packed {
    logic [7:0] entry_count;
    logic [3:0] default_dup_set;
    logic       seven_bit_compare;
  } cfg_regs_t;

endpackage

@@ hw/rtl/multibyte_char_table_search.sv @@
// Channel   Handshake                  Payload
// -------   -------------------------  -------------------------------
// in        start && !busy             in_data   (mbcts_pkg::in_item_t)
// out       out_valid, one cycle       out_data  (mbcts_pkg::out_item_t)
// cfg       cfg_valid && cfg_ready     cfg_index, cfg_data
//
// A load transaction writes the entry store at its accept edge and leaves busy low.
// A lookup probes one entry per cycle (store read plus compare in the probe loop):
// up to floor(log2(count))+1 probes, so at most 8 for 128 entries; the result
// strobe follows the last probe. Empty tables answer in the cycle after accept.
// Reset is synchronous, active low, and clears control state only.
// The receiver cannot stall; results are shown for exactly one cycle.
module multibyte_char_table_search #(
  parameter int MAX_ENTRIES     = mbcts_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_ENTRY_BYTES = mbcts_pkg::DEF_MAX_ENTRY_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mbcts_pkg::in_item_t  in_data,
  output logic                 out_valid,
  output mbcts_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int TW = MAX_ENTRY_BYTES * 8;
  localparam int AW = $clog2(MAX_ENTRIES);

  mbcts_pkg::cfg_regs_t cfg_r, cfg_nxt;
  logic                 accept;
  logic                 wr_en;
  logic [31:0]          idx_ext;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [TW-1:0]        rd_text;
  logic [3:0]           rd_dup;
  logic [6:0]           rd_code;

  assign accept  = start && !busy;
  assign idx_ext = 32'(in_data.entry_index);
  assign wr_en   = accept && (in_data.req_type == mbcts_pkg::REQ_LOAD)
                   && (idx_ext < MAX_ENTRIES);

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        mbcts_pkg::REG_ENTRY_COUNT: cfg_nxt.entry_count       = cfg_data;
        mbcts_pkg::REG_DEFAULT_DUP: cfg_nxt.default_dup_set   = cfg_data[3:0];
        mbcts_pkg::REG_SEVEN_BIT:   cfg_nxt.seven_bit_compare = cfg_data[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mbcts_table #(
    .MAX_ENTRIES     (MAX_ENTRIES),
    .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_text (in_data.entry_text[TW-1:0]),
    .wr_dup  (in_data.entry_dup),
    .wr_code (in_data.entry_code),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_text (rd_text),
    .rd_dup  (rd_dup),
    .rd_code (rd_code)
  );

  mbcts_search #(
    .MAX_ENTRIES     (MAX_ENTRIES),
    .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (accept && (in_data.req_type == mbcts_pkg::REQ_LOOKUP)),
    .query     (in_data.query_bytes[TW-1:0]),
    .canonical (in_data.canonical),
    .cfg       (cfg_r),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_text   (rd_text),
    .rd_dup    (rd_dup),
    .rd_code   (rd_code),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/mbcts_table.sv @@
// Entry store: one write port, one registered read port.
module mbcts_table #(
  parameter int MAX_ENTRIES     = mbcts_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_ENTRY_BYTES = mbcts_pkg::DEF_MAX_ENTRY_BYTES
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
  input  logic [MAX_ENTRY_BYTES*8-1:0] wr_text,
  input  logic [3:0]                   wr_dup,
  input  logic [6:0]                   wr_code,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
  output logic [MAX_ENTRY_BYTES*8-1:0] rd_text,
  output logic [3:0]                   rd_dup,
  output logic [6:0]                   rd_code
);

  localparam int TW = MAX_ENTRY_BYTES * 8;
  localparam int EW = TW + 4 + 7;

  logic [EW-1:0] mem [MAX_ENTRIES];
  logic [EW-1:0] rd_q_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_text, wr_dup, wr_code};
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_text = rd_q_r[EW-1 -: TW];
  assign rd_dup  = rd_q_r[10:7];
  assign rd_code = rd_q_r[6:0];

endmodule

@@ hw/rtl/mbcts_search.sv @@
// Binary search sequencer: one probe per cycle against the entry store.
module mbcts_search #(
  parameter int MAX_ENTRIES     = mbcts_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_ENTRY_BYTES = mbcts_pkg::DEF_MAX_ENTRY_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [MAX_ENTRY_BYTES*8-1:0]   query,
  input  logic                           canonical,
  input  mbcts_pkg::cfg_regs_t           cfg,
  output logic                           busy,
  output logic                           rd_en,
  output logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
  input  logic [MAX_ENTRY_BYTES*8-1:0]   rd_text,
  input  logic [3:0]                     rd_dup,
  input  logic [6:0]                     rd_code,
  output logic                           out_valid,
  output mbcts_pkg::out_item_t           out_data
);

  localparam int TW = MAX_ENTRY_BYTES * 8;
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_PROBE = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        low_r, low_nxt;
  logic [CW-1:0]        hi1_r, hi1_nxt;   // one past the upper bound
  logic [CW-1:0]        mid_r, mid_nxt;
  logic [CW:0]          mid_sum;
  logic [TW-1:0]        query_r;
  logic [3:0]           wanted_r;
  logic                 res_valid_r, res_valid_nxt;
  mbcts_pkg::out_item_t res_r, res_nxt;
  logic [CW-1:0]        count_c;

  // Compare results for the probed entry
  logic [7:0] mask_c;
  logic [3:0] len_c;
  logic       mism_c;
  logic       byte_lower_c;
  logic       hit_c;
  logic       lower_c;

  // Clamp the configured count to the table depth
  assign count_c = (32'(cfg.entry_count) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
                                                        : CW'(cfg.entry_count);

  assign mask_c = cfg.seven_bit_compare ? mbcts_pkg::LOW7_MASK : mbcts_pkg::FULL_MASK;

  // Entry length, first differing byte and its order
  always_comb begin
    logic       run;
    logic [7:0] qb;
    logic [7:0] eb;
    len_c        = '0;
    mism_c       = 1'b0;
    byte_lower_c = 1'b0;
    run          = 1'b1;
    for (int i = 0; i < MAX_ENTRY_BYTES; i++) begin
      qb = query_r[8*i +: 8] & mask_c;
      eb = rd_text[8*i +: 8] & mask_c;
      run = run && (rd_text[8*i +: 8] != 8'd0);
      if (run) begin
        len_c = len_c + 4'd1;
        if (!mism_c && (qb != eb)) begin
          mism_c       = 1'b1;
          byte_lower_c = qb < eb;
        end
      end
    end
  end

  assign hit_c   = !mism_c && (rd_dup == wanted_r);
  assign lower_c = mism_c ? byte_lower_c : (wanted_r < rd_dup);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    hi1_nxt       = hi1_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          low_nxt = '0;
          hi1_nxt = count_c;
          if (count_c == '0) begin
            res_valid_nxt = 1'b1;
            res_nxt       = '0;
          end else begin
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (hit_c) begin
          res_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (len_c != 4'd0) begin
            res_nxt.matched      = 1'b1;
            res_nxt.match_length = len_c;
            res_nxt.char_code    = rd_code;
          end else begin
            res_nxt = '0;
          end
        end else begin
          if (lower_c) begin
            hi1_nxt = mid_r;
          end else begin
            low_nxt = mid_r + CW'(1);
          end
          if (low_nxt >= hi1_nxt) begin
            res_valid_nxt = 1'b1;
            res_nxt       = '0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Next probe address
  assign mid_sum = {1'b0, low_nxt} + {1'b0, hi1_nxt} - (CW+1)'(1);
  assign mid_nxt = mid_sum[CW:1];
  assign rd_en   = (state_nxt == ST_PROBE);
  assign rd_addr = mid_nxt[AW-1:0];

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Search bounds and result payload
  always_ff @(posedge clk) begin
    low_r <= low_nxt;
    hi1_r <= hi1_nxt;
    mid_r <= mid_nxt;
    res_r <= res_nxt;
    if (go && state_r == ST_IDLE) begin
      query_r  <= query;
      wanted_r <= canonical ? 4'd0 : cfg.default_dup_set;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule

@@ hw/rtl/mbcts_checker.sv @@
// Port-level checks for the table search block.
module mbcts_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input mbcts_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input mbcts_pkg::out_item_t out_data
);

  // Reset leaves the block idle with no result pending
  assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // A result is only shown once the search has finished
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result shown while search still busy");

  // A load transaction causes no result and no busy period
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.req_type == mbcts_pkg::REQ_LOAD) |=> !busy && !out_valid)
    else $error("load transaction produced a result or busy");

  // A search that ends always delivers its result
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("search ended without a result");

  // A miss carries zero length and code
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.matched) |-> (out_data.match_length == 4'd0
                                          && out_data.char_code == 7'd0))
    else $error("miss result with nonzero payload");

endmodule

bind multibyte_char_table_search mbcts_checker u_mbcts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

@@ sim/tb_multibyte_char_table_search.sv @@
module tb_multibyte_char_table_search;
  import mbcts_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int TABLE_DEPTH  = DEF_MAX_ENTRIES;
  localparam int RANDOM_ITEMS = 320;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_data;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  // Shadow of the entry store and registers, updated at each accepted transaction
  logic [63:0] shadow_text [TABLE_DEPTH];
  logic [3:0]  shadow_dup  [TABLE_DEPTH];
  logic [6:0]  shadow_code [TABLE_DEPTH];
  cfg_regs_t   shadow_cfg;

  out_item_t expected_results [$];
  out_item_t oldest_lookup;
  int        mismatches;
  int        items_sent;
  bit        start_q;
  bit        cfgv_q;
  bit        gaps_on;

  multibyte_char_table_search i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * 600000);
    $display("CHECKS FAILED");
    $finish;
  end

  // Bytes before the first zero, at most eight
  function automatic int text_length(input logic [63:0] t);
    int n;
    n = 0;
    while (n < DEF_MAX_ENTRY_BYTES && t[8*n +: 8] != 8'h00) n++;
    return n;
  endfunction

  // Binary search over the shadow table for an entry prefixing the buffer
  function automatic out_item_t search_table(input logic [63:0] q, input logic canon);
    out_item_t  res;
    logic [7:0] msk;
    logic [7:0] qb;
    logic [7:0] eb;
    logic [3:0] want;
    int         lo;
    int         hi;
    int         mid;
    int         len;
    int         k;
    bit         lower;
    bit         done;
    res  = '0;
    msk  = shadow_cfg.seven_bit_compare ? LOW7_MASK : FULL_MASK;
    want = canon ? 4'd0 : shadow_cfg.default_dup_set;
    lo   = 0;
    hi   = ((shadow_cfg.entry_count > 8'd128) ? TABLE_DEPTH : int'(shadow_cfg.entry_count)) - 1;
    done = 1'b0;
    while (!done && lo <= hi) begin
      mid   = (lo + hi) >> 1;
      len   = text_length(shadow_text[mid]);
      k     = 0;
      lower = 1'b0;
      while (k < len && ((q[8*k +: 8] ^ shadow_text[mid][8*k +: 8]) & msk) == 8'h00) k++;
      if (k == len) begin
        if (shadow_dup[mid] == want) begin
          // a zero-length entry ends the search without a match
          if (len != 0) begin
            res.matched      = 1'b1;
            res.match_length = 4'(len);
            res.char_code    = shadow_code[mid];
          end
          done = 1'b1;
        end
        lower = want < shadow_dup[mid];
      end else begin
        qb    = q[8*k +: 8] & msk;
        eb    = shadow_text[mid][8*k +: 8] & msk;
        lower = qb < eb;
      end
      if (!done) begin
        if (lower) hi = mid - 1;
        else lo = mid + 1;
      end
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input out_item_t want_res,
                               input out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected matched=%0b len=%0d code=%0d, got matched=%0b len=%0d code=%0d",
               $time, what, want_res.matched, want_res.match_length, want_res.char_code,
               got.matched, got.match_length, got.char_code);
  endtask

  // Each result strobe retires the oldest pending lookup
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result with no lookup pending", 'x, out_data);
      end else begin
        oldest_lookup = expected_results.pop_front();
        if (out_data.matched !== oldest_lookup.matched ||
            out_data.match_length !== oldest_lookup.match_length ||
            out_data.char_code !== oldest_lookup.char_code)
          note_mismatch("result mismatch", oldest_lookup, out_data);
      end
    end
  end

  // Drive helpers; start_q and cfgv_q mirror what has been scheduled
  task automatic drop_start();
    if (start_q) begin
      start   <= 1'b0;
      start_q = 1'b0;
    end
  endtask

  task automatic drop_cfg();
    if (cfgv_q) begin
      cfg_valid <= 1'b0;
      cfgv_q    = 1'b0;
    end
  endtask

  task automatic pause(input int n);
    drop_start();
    drop_cfg();
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 18));
  endtask

  // Wait until every lookup has answered and the block has gone quiet
  task automatic settle();
    pause(0);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    drop_start();
    cfg_valid <= 1'b1;
    cfgv_q    = 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_ENTRY_COUNT: shadow_cfg.entry_count       = val;
      REG_DEFAULT_DUP: shadow_cfg.default_dup_set   = val[3:0];
      REG_SEVEN_BIT:   shadow_cfg.seven_bit_compare = val[0];
      default: ;  // unmapped index, no effect
    endcase
  endtask

  // One input transaction; start stays high so back-to-back items need no bubble
  task automatic send_item(input in_item_t it);
    drop_cfg();
    start   <= 1'b1;
    start_q = 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    if (it.req_type == REQ_LOOKUP) begin
      expected_results.push_back(search_table(it.query_bytes, it.canonical));
    end else begin
      shadow_text[it.entry_index] = it.entry_text;
      shadow_dup[it.entry_index]  = it.entry_dup;
      shadow_code[it.entry_index] = it.entry_code;
    end
  endtask

  // Unused fields carry random bits as well
  function automatic in_item_t random_item();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  task automatic do_load(input int idx, input logic [63:0] txt, input logic [3:0] dup,
                         input logic [6:0] code);
    in_item_t it;
    it             = random_item();
    it.req_type    = REQ_LOAD;
    it.entry_index = 7'(idx);
    it.entry_text  = txt;
    it.entry_dup   = dup;
    it.entry_code  = code;
    send_item(it);
  endtask

  task automatic do_lookup(input logic [63:0] q, input logic canon);
    in_item_t it;
    it             = random_item();
    it.req_type    = REQ_LOOKUP;
    it.query_bytes = q;
    it.canonical   = canon;
    send_item(it);
  endtask

  // Build n entries ordered by masked text then set, and load them from slot 0
  task automatic load_sorted_table(input int n);
    logic [63:0] txt  [TABLE_DEPTH];
    logic [3:0]  dp   [TABLE_DEPTH];
    logic [67:0] rank [TABLE_DEPTH];
    logic [63:0] t_tmp;
    logic [3:0]  d_tmp;
    logic [67:0] r_tmp;
    logic [7:0]  msk;
    logic [7:0]  b;
    int          len;
    int          j;
    msk = shadow_cfg.seven_bit_compare ? LOW7_MASK : FULL_MASK;
    for (int i = 0; i < n; i++) begin
      len     = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
      txt[i]  = '0;
      rank[i] = '0;
      for (int k = 0; k < len; k++) begin
        // small alphabet gives shared prefixes; high bit variants matter in seven-bit mode
        if ($urandom_range(0, 1) == 0) begin
          b = 8'h41 + 8'($urandom_range(0, 2));
          if ($urandom_range(0, 3) == 0) b[7] = 1'b1;
        end else begin
          b = 8'($urandom_range(1, 255));
        end
        txt[i][8*k +: 8]      = b;
        rank[i][67-8*k -: 8] = b & msk;
      end
      // junk after the terminator must be ignored
      if (len < 7 && $urandom_range(0, 7) == 0)
        for (int k = len + 1; k < 8; k++) txt[i][8*k +: 8] = 8'($urandom);
      case ($urandom_range(0, 5))
        0, 1, 2: dp[i] = 4'd0;
        3, 4:    dp[i] = shadow_cfg.default_dup_set;
        default: dp[i] = 4'($urandom);
      endcase
      rank[i][3:0] = dp[i];
    end
    // insertion sort on rank
    for (int i = 1; i < n; i++) begin
      t_tmp = txt[i];
      d_tmp = dp[i];
      r_tmp = rank[i];
      j     = i;
      while (j > 0 && rank[j-1] > r_tmp) begin
        txt[j]  = txt[j-1];
        dp[j]   = dp[j-1];
        rank[j] = rank[j-1];
        j--;
      end
      txt[j]  = t_tmp;
      dp[j]   = d_tmp;
      rank[j] = r_tmp;
    end
    for (int i = 0; i < n; i++) begin
      maybe_gap();
      do_load(i, txt[i], dp[i], 7'($urandom));
    end
  endtask

  // Lookups against the empty table straight out of reset
  task automatic test_empty_table();
    do_lookup(64'h0, 1'b1);
    do_lookup('1, 1'b0);
  endtask

  // Every slot written once so that any count is legal from here on
  task automatic test_fill_table();
    gaps_on = 1'b1;
    load_sorted_table(TABLE_DEPTH);
  endtask

  task automatic test_directed_cases();
    gaps_on = 1'b0;
    settle();
    write_reg(REG_ENTRY_COUNT, 8'd5);
    write_reg(REG_DEFAULT_DUP, 8'd3);
    write_reg(REG_SEVEN_BIT, 8'd0);
    do_load(0, 64'h0, 4'd0, 7'd5);                    // empty text
    do_load(1, 64'h41, 4'd0, 7'd1);
    do_load(2, 64'h41, 4'd3, 7'd2);                   // same text, other set
    do_load(3, 64'hDEAD_BEEF_0000_42C1, 4'd0, 7'd3);  // junk past terminator
    do_load(4, '1, 4'd15, 7'd127);                    // full eight bytes
    do_lookup(64'h0, 1'b1);
    do_lookup(64'h41, 1'b1);
    do_lookup(64'h41, 1'b0);
    do_lookup(64'h42C1, 1'b1);
    do_lookup('1, 1'b1);
    settle();
    write_reg(REG_DEFAULT_DUP, 8'hFF);
    do_lookup('1, 1'b0);
    // seven-bit compare: high bit ignored, terminator still raw
    settle();
    write_reg(REG_SEVEN_BIT, 8'hFF);
    do_lookup(64'h4241, 1'b0);
    do_lookup(64'hC1, 1'b0);
    // unmapped register, then a count past the table size
    settle();
    write_reg(REG_UNMAPPED, 8'h00);
    write_reg(REG_ENTRY_COUNT, 8'hFF);
    do_lookup(shadow_text[100], 1'b1);
    do_lookup(shadow_text[100], 1'b0);
    settle();
    write_reg(REG_ENTRY_COUNT, 8'd1);
    do_lookup(64'h0, 1'b1);
    do_lookup(64'h0, 1'b0);
    settle();
    write_reg(REG_ENTRY_COUNT, 8'd128);
    write_reg(REG_SEVEN_BIT, 8'd0);
    write_reg(REG_DEFAULT_DUP, 8'd0);
    do_lookup(shadow_text[64], 1'b1);
  endtask

  // Phases of random settings, mostly sorted tables and lookups aimed at entries
  task automatic test_random_traffic();
    int          first;
    int          eff;
    int          pick;
    int          len;
    logic [7:0]  cnt;
    logic [63:0] q;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      settle();
      // last stretch of the run has no idling
      gaps_on = (items_sent - first < RANDOM_ITEMS * 4 / 5) && $urandom_range(0, 2) != 0;
      pick = $urandom_range(0, 9);
      if (pick == 0) cnt = 8'd0;
      else if (pick == 1) cnt = 8'd128;
      else if (pick == 2) cnt = 8'($urandom_range(129, 255));
      else cnt = 8'($urandom_range(1, 24));
      write_reg(REG_ENTRY_COUNT, cnt);
      write_reg(REG_DEFAULT_DUP, 8'($urandom));
      write_reg(REG_SEVEN_BIT, 8'($urandom));
      if ($urandom_range(0, 5) == 0) write_reg(REG_UNMAPPED, 8'($urandom));
      eff = (cnt > 8'd128) ? TABLE_DEPTH : int'(cnt);

      // table contents: unordered noise, a fresh ordered table, or what is left
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          maybe_gap();
          do_load(int'(7'($urandom)), {$urandom, $urandom}, 4'($urandom), 7'($urandom));
        end
      end else if (eff <= 24 || $urandom_range(0, 3) == 0) begin
        load_sorted_table(eff);
      end

      repeat ($urandom_range(10, 30)) begin
        maybe_gap();
        if ($urandom_range(0, 19) == 0) begin
          do_load(int'(7'($urandom)), {$urandom, $urandom}, 4'($urandom), 7'($urandom));
        end else begin
          q = {$urandom, $urandom};
          if (eff > 0 && $urandom_range(0, 3) != 0) begin
            // buffer starting with a table entry's text
            pick = $urandom_range(0, eff - 1);
            len  = text_length(shadow_text[pick]);
            for (int k = 0; k < len; k++) begin
              q[8*k +: 8] = shadow_text[pick][8*k +: 8];
              if ($urandom_range(0, shadow_cfg.seven_bit_compare ? 2 : 15) == 0)
                q[8*k+7] = ~q[8*k+7];
            end
            if ($urandom_range(0, 3) == 0)
              for (int k = len; k < 8; k++) q[8*k +: 8] = 8'h00;
          end else begin
            case ($urandom_range(0, 7))
              0:       q = '0;
              1:       q = '1;
              default: ;
            endcase
          end
          do_lookup(q, 1'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_data    <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    shadow_cfg = '0;
    mismatches = 0;
    items_sent = 0;
    start_q    = 1'b0;
    cfgv_q     = 1'b0;
    gaps_on    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_fill_table();
    test_directed_cases();
    test_random_traffic();
    settle();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
